FILE: sv/assert_macros.svh
// Assertion macros shared by the lock table RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop on every rising clock edge, disabled while reset is low.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that cond never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

FILE: sv/ltm_pkg.sv
// Types and constants of the lock table manager.
// No dependencies; used by the channel interfaces and the top level.
package ltm_pkg;

    localparam int OP_W     = 2;
    localparam int CLIENT_W = 31;
    localparam int ID_W     = 64;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 7;

    typedef logic [OP_W-1:0]            t_op;
    typedef logic [CLIENT_W-1:0]        t_client;
    typedef logic [ID_W-1:0]            t_lock_id;
    typedef logic [STATUS_W-1:0]        t_status;
    typedef logic signed [VALUE_W-1:0]  t_value;
    typedef logic [COUNT_W-1:0]         t_count;

    // Operation codes
    localparam t_op OP_ACQUIRE = 2'd0;
    localparam t_op OP_RELEASE = 2'd1;
    localparam t_op OP_QUERY   = 2'd2;
    localparam t_op OP_UNUSED  = 2'd3;

    // Status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_NOENT = 2'd1;
    localparam t_status ST_BUSY  = 2'd2;
    localparam t_status ST_FULL  = 2'd3;

    // Query answers and the owner mark of a freed lock
    localparam t_value  VAL_UNKNOWN = -32'sd2;
    localparam t_value  VAL_OTHER   = -32'sd1;
    localparam t_value  VAL_ZERO    = 32'sd0;
    localparam t_client OWNER_FREE  = {CLIENT_W{1'b1}};
    localparam t_count  COUNT_MAX   = {COUNT_W{1'b1}};

endpackage

FILE: sv/ltm_req_if.sv
// Request channel of the lock table manager: valid/ready plus one request beat.
// Depends on ltm_pkg.
interface ltm_req_if;
    logic                valid;
    logic                ready;
    ltm_pkg::t_op        operation;
    ltm_pkg::t_client    client;
    ltm_pkg::t_lock_id   lock_id;

    modport source (output valid, operation, client, lock_id, input ready);
    modport sink   (input valid, operation, client, lock_id, output ready);
endinterface

FILE: sv/ltm_rsp_if.sv
// Response channel of the lock table manager: valid/ready plus one response beat.
// Depends on ltm_pkg.
interface ltm_rsp_if;
    logic              valid;
    logic              ready;
    ltm_pkg::t_status  status;
    ltm_pkg::t_value   value;

    modport source (output valid, status, value, input ready);
    modport sink   (input valid, status, value, output ready);
endinterface

FILE: sv/lock_table_manager.sv
// Lock table manager top level: associative table of named locks.
// Depends on ltm_pkg, ltm_req_if, ltm_rsp_if and assert_macros.svh.
//
// Usage:
//   i_req carries one request beat (operation, client, lock_id); o_rsp returns
//   exactly one response beat (status, value) per request, in request order.
//   Acquire takes or creates a lock, release frees it, query reports on it
//   without changing anything.
//   A request beat is captured in the input register, matched against all
//   ENTRIES lock ids in parallel (one comparator per entry), and its answer
//   is written to the result register once that register can take it.
//   Throughput is one request per cycle unless the receiver stalls; the table
//   update of one request is visible to the very next one, since both are written on the same edge.
//   When the receiver stalls, the result register holds its beat and the
//   input register holds the next request; i_req.ready drops only once both
//   are full, so one beat can be accepted while a finished answer waits.
//   Reset (i_rst_n low, synchronous) empties the table at once: all entries
//   invalid and free, held count zero, both registers empty. No clearing
//   pass is needed; requests are taken as soon as reset is released.
module lock_table_manager #(
    parameter int ENTRIES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ltm_req_if.sink   i_req,
    ltm_rsp_if.source o_rsp
);

`include "assert_macros.svh"

    // Input register
    logic                r_in_valid;
    ltm_pkg::t_op        r_in_op;
    ltm_pkg::t_client    r_in_client;
    ltm_pkg::t_lock_id   r_in_id;

    // Result register
    logic                r_out_valid;
    ltm_pkg::t_status    r_out_status;
    ltm_pkg::t_value     r_out_value;

    // Table: one lane per entry
    logic [ENTRIES-1:0]  r_valid;
    logic [ENTRIES-1:0]  r_held;
    ltm_pkg::t_lock_id   r_lock_id [ENTRIES];
    ltm_pkg::t_client    r_owner   [ENTRIES];
    ltm_pkg::t_count     r_held_count;

    logic                w_advance;
    logic [ENTRIES-1:0]  w_match;
    logic [ENTRIES-1:0]  w_free_slot;
    logic                w_hit;
    logic                w_hit_held;
    logic                w_full;
    logic                w_grant;
    ltm_pkg::t_client    w_owner;

    logic [ENTRIES-1:0]  w_take;
    logic [ENTRIES-1:0]  w_create;
    logic [ENTRIES-1:0]  w_release;
    ltm_pkg::t_count     n_held_count;
    ltm_pkg::t_status    n_status;
    ltm_pkg::t_value     n_value;

    // Work on the captured request when the result register can take its answer.
    assign w_advance   = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_advance;

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_status;
    assign o_rsp.value  = r_out_value;

    // Parallel match; lock ids are unique among valid entries, so at most one hits.
    always_comb begin
        w_owner = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_lock_id[i] == r_in_id);
            w_owner    = w_owner | (w_match[i] ? r_owner[i] : '0);
        end
    end

    assign w_hit       = |w_match;
    assign w_hit_held  = |(w_match & r_held);
    assign w_full      = &r_valid;
    // Lowest invalid entry, one-hot
    assign w_free_slot = ~r_valid & (r_valid + ENTRIES'(1));
    assign w_grant     = w_advance && (|w_take);

    always_comb begin
        w_take       = '0;
        w_create     = '0;
        w_release    = '0;
        n_held_count = r_held_count;
        n_status     = ltm_pkg::ST_OK;
        n_value      = ltm_pkg::VAL_ZERO;
        unique case (r_in_op)
            ltm_pkg::OP_ACQUIRE: begin
                if (w_hit_held) begin
                    n_status = ltm_pkg::ST_BUSY;
                end else if (!w_hit && w_full) begin
                    n_status = ltm_pkg::ST_FULL;
                end else begin
                    if (w_hit) begin
                        w_take = w_match;
                    end else begin
                        w_take   = w_free_slot;
                        w_create = w_free_slot;
                    end
                    if (r_held_count != ltm_pkg::COUNT_MAX) begin
                        n_held_count = r_held_count + ltm_pkg::COUNT_W'(1);
                    end
                    n_value = $signed({{(ltm_pkg::VALUE_W - ltm_pkg::COUNT_W){1'b0}},
                                       n_held_count});
                end
            end
            ltm_pkg::OP_RELEASE: begin
                n_value = $signed({{(ltm_pkg::VALUE_W - ltm_pkg::COUNT_W){1'b0}},
                                   r_held_count});
                if (!w_hit) begin
                    n_status = ltm_pkg::ST_NOENT;
                end else begin
                    w_release = w_match;
                    // The count drops only when a held lock is freed.
                    if (w_hit_held && (r_held_count != '0)) begin
                        n_held_count = r_held_count - ltm_pkg::COUNT_W'(1);
                    end
                end
            end
            ltm_pkg::OP_QUERY: begin
                if (!w_hit) begin
                    n_value = ltm_pkg::VAL_UNKNOWN;
                end else if (w_owner != r_in_client) begin
                    n_value = ltm_pkg::VAL_OTHER;
                end else if (!w_hit_held) begin
                    n_value = ltm_pkg::VAL_ZERO;
                end else begin
                    n_value = $signed({1'b0, w_owner});
                end
            end
            ltm_pkg::OP_UNUSED: begin
                n_status = ltm_pkg::ST_NOENT;
            end
            default: begin
                n_status = ltm_pkg::ST_NOENT;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_valid      <= '0;
            r_held       <= '0;
            r_held_count <= '0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (!r_out_valid || o_rsp.ready) begin
                r_out_valid <= w_advance;
            end
            if (w_advance) begin
                r_valid      <= r_valid | w_create;
                r_held       <= (r_held | w_take) & ~w_release;
                r_held_count <= n_held_count;
            end
        end
    end

    // Payload: request capture, answer, lock ids and owners
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_op     <= i_req.operation;
            r_in_client <= i_req.client;
            r_in_id     <= i_req.lock_id;
        end
        if (w_advance) begin
            r_out_status <= n_status;
            r_out_value  <= n_value;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_advance && w_create[i]) begin
                r_lock_id[i] <= r_in_id;
            end
            if (w_advance && w_take[i]) begin
                r_owner[i] <= r_in_client;
            end else if (w_advance && w_release[i]) begin
                r_owner[i] <= ltm_pkg::OWNER_FREE;
            end
        end
    end

    // Lock ids stay unique, so a request never matches two entries.
    `ASSERT_AT(a_match_unique, i_clk, i_rst_n, $onehot0(w_match), "two entries match one id")
    // Only a valid entry can be held.
    `ASSERT_NEVER(a_held_valid, i_clk, i_rst_n, (r_held & ~r_valid) != '0, "held entry invalid")
    // The count never exceeds the number of held locks.
    `ASSERT_AT(a_count_bound, i_clk, i_rst_n, r_held_count <= $countones(r_held), "count too high")
    // A granted acquire leaves a nonzero count.
    `ASSERT_AT(a_grant, i_clk, i_rst_n, w_grant |=> (r_held_count != '0), "zero after grant")

endmodule
